// ===== src/assert_macros.svh =====
// assertion macros for the rtl files, used by the allocator top
// every macro samples on clk_i and is disabled while rst_ni is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check with an error message
`define FFBA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

`endif

// ===== src/ffba_pkg.sv =====
// types and defaults for the first-fit block allocator
// no dependencies
`timescale 1ns / 1ps

package ffba_pkg;

  localparam int unsigned PoolBytesDef   = 65536;
  localparam int unsigned HeaderBytesDef = 24;
  localparam int unsigned MaxBlocksDef   = 256;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_NO_FIT     = 2'd1,
    ST_BAD_OFFSET = 2'd2,
    ST_FULL       = 2'd3
  } status_e;

  typedef enum logic {
    ACT_ALLOC = 1'b0,
    ACT_FREE  = 1'b1
  } action_e;

  typedef struct packed {
    action_e     action;
    logic [15:0] request_size;
    logic [15:0] block_offset;
  } in_t;

  typedef struct packed {
    status_e     status;
    logic [15:0] data_offset;
  } out_t;

endpackage

// ===== src/first_fit_block_allocator_top.sv =====
// first-fit block allocator with coalescing, whole block in one module
// depends on ffba_pkg and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"
//
// Usage:
// in_word_i carries one request: allocate request_size bytes, or free the
// block whose data starts at block_offset. out_word_o returns a status and,
// for a good allocate, the data offset. Both sides use valid/ready.
// One request is worked on at a time. Each request walks the block chain
// from the pool start, one block table read per cycle through a memory
// with a registered read port. A split writes the remainder row and then
// the allocated row; a free writes its merged or freed row at the end.
// After reset the pool is one free block and every other table slot is on
// the spare stack; no clearing pass is needed, the block takes requests at
// once. The result sits in an output register: a new request is taken while
// a finished word waits, and a stalled receiver only holds back the next
// result, not the next acceptance.
module first_fit_block_allocator_top #(
  parameter int unsigned POOL_BYTES   = ffba_pkg::PoolBytesDef,
  parameter int unsigned HEADER_BYTES = ffba_pkg::HeaderBytesDef,
  parameter int unsigned MAX_BLOCKS   = ffba_pkg::MaxBlocksDef
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  ffba_pkg::in_t  in_word_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output ffba_pkg::out_t out_word_o
);

  localparam int unsigned SW = $clog2(MAX_BLOCKS);
  localparam int unsigned CW = $clog2(MAX_BLOCKS + 1);
  // row layout: free, has_next, start, size, next
  localparam int unsigned NX_LO = 0;
  localparam int unsigned SZ_LO = SW;
  localparam int unsigned ST_LO = SW + 16;
  localparam int unsigned HN_B  = SW + 32;
  localparam int unsigned FR_B  = SW + 33;
  localparam int unsigned EW    = SW + 34;
  localparam logic [EW-1:0] RST_ROW =
    {1'b1, 1'b0, 16'd0, 16'(POOL_BYTES - HEADER_BYTES), SW'(0)};
  localparam logic [16:0] HDR = 17'(HEADER_BYTES);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_ACHK = 3'd1;
  localparam logic [2:0] S_APOP = 3'd2;
  localparam logic [2:0] S_AWR  = 3'd3;
  localparam logic [2:0] S_FCHK = 3'd4;
  localparam logic [2:0] S_FNXT = 3'd5;
  localparam logic [2:0] S_FMRG = 3'd6;
  localparam logic [2:0] S_FIN  = 3'd7;

  // memories
  logic [EW-1:0] tbl_mem [MAX_BLOCKS];
  logic [SW-1:0] stk_mem [MAX_BLOCKS];

  logic [2:0]    state_q, state_d;
  logic [SW-1:0] cur_q, cur_d, prev_slot_q, prev_slot_d, ns_q, ns_d;
  logic          have_prev_q, have_prev_d;
  logic [CW-1:0] count_q, count_d, minc_q, minc_d;
  logic          fresh_q, fresh_d;
  logic          out_valid_q, out_valid_d;
  ffba_pkg::in_t  req_q, req_d;
  ffba_pkg::out_t res_q, res_d, out_q, out_d;
  logic [EW-1:0] b_q, b_d, prev_q, prev_d;

  logic          tbl_re, tbl_we, stk_re, stk_we;
  logic [SW-1:0] tbl_ra, tbl_wa, stk_ra, stk_wa, stk_wd;
  logic [EW-1:0] tbl_wd;
  logic [EW-1:0] tbl_rd_q;
  logic          rd_fresh_q, stk_rst_q;
  logic [SW-1:0] stk_rd_q, stk_rstv_q;

  logic [EW-1:0] ent, row;
  logic [SW-1:0] ns, pop_idx;
  logic [CW-1:0] cnt_dec;
  logic [16:0]   want, rest, sum17;

  assign ent     = rd_fresh_q ? RST_ROW : tbl_rd_q;
  assign ns      = stk_rst_q ? stk_rstv_q : stk_rd_q;
  assign cnt_dec = count_q - CW'(1);
  assign pop_idx = cnt_dec[SW-1:0];
  assign want    = {1'b0, req_q.request_size};
  assign rest    = {1'b0, ent[SZ_LO+:16]} - want;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  always_comb begin
    state_d     = state_q;
    cur_d       = cur_q;
    prev_slot_d = prev_slot_q;
    ns_d        = ns_q;
    have_prev_d = have_prev_q;
    count_d     = count_q;
    minc_d      = minc_q;
    fresh_d     = fresh_q;
    req_d       = req_q;
    res_d       = res_q;
    b_d         = b_q;
    prev_d      = prev_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    tbl_re      = 1'b0;
    tbl_ra      = '0;
    tbl_we      = 1'b0;
    tbl_wa      = '0;
    tbl_wd      = '0;
    stk_re      = 1'b0;
    stk_ra      = '0;
    stk_we      = 1'b0;
    stk_wa      = '0;
    stk_wd      = '0;
    row         = '0;
    sum17       = '0;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          req_d       = in_word_i;
          cur_d       = '0;
          have_prev_d = 1'b0;
          tbl_re      = 1'b1;
          state_d     = (in_word_i.action == ffba_pkg::ACT_ALLOC) ? S_ACHK : S_FCHK;
        end
      end
      S_ACHK: begin
        b_d = ent;
        if (ent[FR_B] && ({1'b0, ent[SZ_LO+:16]} >= want)) begin
          if (rest > HDR) begin
            if (count_q == '0) begin
              res_d   = '{status: ffba_pkg::ST_FULL, data_offset: 16'd0};
              state_d = S_FIN;
            end else begin
              stk_re  = 1'b1;
              stk_ra  = pop_idx;
              count_d = cnt_dec;
              if (cnt_dec < minc_q) begin
                minc_d = cnt_dec;
              end
              state_d = S_APOP;
            end
          end else begin
            row       = ent;
            row[FR_B] = 1'b0;
            tbl_we    = 1'b1;
            tbl_wa    = cur_q;
            tbl_wd    = row;
            sum17     = {1'b0, ent[ST_LO+:16]} + HDR;
            res_d     = '{status: ffba_pkg::ST_OK, data_offset: sum17[15:0]};
            state_d   = S_FIN;
          end
        end else if (!ent[HN_B]) begin
          res_d   = '{status: ffba_pkg::ST_NO_FIT, data_offset: 16'd0};
          state_d = S_FIN;
        end else begin
          tbl_re = 1'b1;
          tbl_ra = ent[NX_LO+:SW];
          cur_d  = ent[NX_LO+:SW];
        end
      end
      S_APOP: begin
        // new free remainder after the allocated part
        ns_d             = ns;
        sum17            = {1'b0, b_q[ST_LO+:16]} + HDR + want;
        row[FR_B]        = 1'b1;
        row[HN_B]        = b_q[HN_B];
        row[ST_LO+:16]   = sum17[15:0];
        row[NX_LO+:SW]   = b_q[NX_LO+:SW];
        row[SZ_LO+:16]   = b_q[SZ_LO+:16] - req_q.request_size - 16'(HEADER_BYTES);
        tbl_we           = 1'b1;
        tbl_wa           = ns;
        tbl_wd           = row;
        state_d          = S_AWR;
      end
      S_AWR: begin
        row            = b_q;
        row[FR_B]      = 1'b0;
        row[HN_B]      = 1'b1;
        row[NX_LO+:SW] = ns_q;
        row[SZ_LO+:16] = req_q.request_size;
        tbl_we         = 1'b1;
        tbl_wa         = cur_q;
        tbl_wd         = row;
        sum17          = {1'b0, b_q[ST_LO+:16]} + HDR;
        res_d          = '{status: ffba_pkg::ST_OK, data_offset: sum17[15:0]};
        state_d        = S_FIN;
      end
      S_FCHK: begin
        sum17 = {1'b0, ent[ST_LO+:16]} + HDR;
        if (sum17 == {1'b0, req_q.block_offset}) begin
          b_d       = ent;
          b_d[FR_B] = 1'b1;
          if (ent[FR_B]) begin
            res_d   = '{status: ffba_pkg::ST_BAD_OFFSET, data_offset: 16'd0};
            state_d = S_FIN;
          end else if (ent[HN_B]) begin
            tbl_re  = 1'b1;
            tbl_ra  = ent[NX_LO+:SW];
            state_d = S_FNXT;
          end else begin
            state_d = S_FMRG;
          end
        end else if (!ent[HN_B]) begin
          res_d   = '{status: ffba_pkg::ST_BAD_OFFSET, data_offset: 16'd0};
          state_d = S_FIN;
        end else begin
          prev_d      = ent;
          prev_slot_d = cur_q;
          have_prev_d = 1'b1;
          cur_d       = ent[NX_LO+:SW];
          tbl_re      = 1'b1;
          tbl_ra      = ent[NX_LO+:SW];
        end
      end
      S_FNXT: begin
        // absorb a free successor and return its slot
        if (ent[FR_B]) begin
          sum17            = {1'b0, b_q[SZ_LO+:16]} + {1'b0, ent[SZ_LO+:16]} + HDR;
          b_d[SZ_LO+:16]   = sum17[15:0];
          b_d[HN_B]        = ent[HN_B];
          b_d[NX_LO+:SW]   = ent[NX_LO+:SW];
          stk_we           = 1'b1;
          stk_wa           = count_q[SW-1:0];
          stk_wd           = b_q[NX_LO+:SW];
          count_d          = count_q + CW'(1);
        end
        state_d = S_FMRG;
      end
      S_FMRG: begin
        if (have_prev_q && prev_q[FR_B]) begin
          sum17            = {1'b0, prev_q[SZ_LO+:16]} + {1'b0, b_q[SZ_LO+:16]} + HDR;
          row              = prev_q;
          row[SZ_LO+:16]   = sum17[15:0];
          row[HN_B]        = b_q[HN_B];
          row[NX_LO+:SW]   = b_q[NX_LO+:SW];
          tbl_wa           = prev_slot_q;
          stk_we           = 1'b1;
          stk_wa           = count_q[SW-1:0];
          stk_wd           = cur_q;
          count_d          = count_q + CW'(1);
        end else begin
          row    = b_q;
          tbl_wa = cur_q;
        end
        tbl_we  = 1'b1;
        tbl_wd  = row;
        res_d   = '{status: ffba_pkg::ST_OK, data_offset: 16'd0};
        state_d = S_FIN;
      end
      S_FIN: begin
        if (!out_valid_q || out_ready_i) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (tbl_we && (tbl_wa == '0)) begin
      fresh_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      have_prev_q <= 1'b0;
      count_q     <= CW'(MAX_BLOCKS - 1);
      minc_q      <= CW'(MAX_BLOCKS - 1);
      fresh_q     <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      have_prev_q <= have_prev_d;
      count_q     <= count_d;
      minc_q      <= minc_d;
      fresh_q     <= fresh_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q       <= cur_d;
    prev_slot_q <= prev_slot_d;
    ns_q        <= ns_d;
    req_q       <= req_d;
    res_q       <= res_d;
    b_q         <= b_d;
    prev_q      <= prev_d;
    out_q       <= out_d;
  end

  // block table, one read and one write port
  always_ff @(posedge clk_i) begin
    if (tbl_we) begin
      tbl_mem[tbl_wa] <= tbl_wd;
    end
    if (tbl_re) begin
      tbl_rd_q   <= tbl_mem[tbl_ra];
      rd_fresh_q <= fresh_q && (tbl_ra == '0);
    end
  end

  // spare slot stack; entries below the lowest count seen keep reset values
  always_ff @(posedge clk_i) begin
    if (stk_we) begin
      stk_mem[stk_wa] <= stk_wd;
    end
    if (stk_re) begin
      stk_rd_q   <= stk_mem[stk_ra];
      stk_rst_q  <= (CW'(stk_ra) < minc_q);
      stk_rstv_q <= SW'(MAX_BLOCKS - 1) - stk_ra;
    end
  end

  `FFBA_ASSERT(a_count_range, count_q <= CW'(MAX_BLOCKS - 1), "spare count out of range")
  `FFBA_ASSERT(a_minc_le_count, minc_q <= count_q, "low mark above spare count")
  `FFBA_ASSERT(a_accept_busy, in_valid_i && in_ready_o |=> state_q != S_IDLE, "accept did not start")

endmodule
